[sv/sobel_edge_magnitude_3x3_core_assert.svh]
// Assertion macros for the Sobel edge magnitude core.
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_CORE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_CORE_ASSERT_SVH

// Condition holds in the same cycle.
`define SOBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sobel core assertion failed");

// Condition holds in the following cycle.
`define SOBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sobel core assertion failed");

`endif

[sv/sobm_pkg.sv]
// Shared types and constants for the Sobel edge magnitude core.
`timescale 1ns / 1ps
package sobm_pkg;

  localparam int PIX_W  = 8;
  localparam int MAG_W  = 8;
  localparam int CCOL_W = 10;
  localparam int ROW_W  = 12;
  localparam int FW_W   = 11;
  localparam int FH_W   = 12;
  localparam int CFG_W  = 12;
  localparam int CFG_IDX_W = 2;

  localparam int MIN_DIM      = 3;
  localparam int INTERIOR_MIN = 2;
  localparam int MAG_MAX      = 255;

  localparam int VSUM_W  = PIX_W + 2;
  localparam int VDIFF_W = PIX_W + 1;
  localparam int GRAD_W  = PIX_W + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_pix_t;

  typedef struct packed {
    logic [VSUM_W-1:0]         vsum;
    logic signed [VDIFF_W-1:0] vdiff;
  } col_terms_t;

  typedef struct packed {
    logic              emit;
    logic              frame_end;
    logic [CCOL_W-1:0] ccol;
    logic [ROW_W-1:0]  crow;
  } item_tag_t;

endpackage

[sv/sobel_edge_magnitude_3x3_core.sv]
// Sobel 3x3 edge magnitude core: line stores, window cell chain, output register.
// Pipeline: stage 1 pixel and line store read, stage 2 window cells, then the output register.
// Throughput: one pixel per clock unless output stalls; set by line store read and cell chain.
// Border pixels produce no output transfer; the result for centre (r-1,c-1) follows pixel (r,c).
// Reset: counters, window cells, pipeline valids cleared; size returns to 640 x 480.
// Line store contents are not cleared by reset.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_3x3_core_assert.svh"
module sobel_edge_magnitude_3x3_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sobm_pkg::PIX_W-1:0]      in_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sobm_pkg::MAG_W-1:0]      out_magnitude,
  output logic [sobm_pkg::CCOL_W-1:0]     out_centre_col,
  output logic [sobm_pkg::ROW_W-1:0]      out_centre_row,
  output logic                            out_frame_end,
  input  logic                            cfg_we,
  input  logic [sobm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sobm_pkg::CFG_W-1:0]      cfg_wdata
);
  import sobm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
  localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
  localparam logic [WW-1:0] W_MIN = WW'(MIN_DIM);
  localparam logic [FH_W-1:0] H_MIN = FH_W'(MIN_DIM);

  // configuration
  logic [FW_W-1:0] fw_r, fw_nxt;
  logic [FH_W-1:0] fh_r, fh_nxt;

  always_comb begin
    fw_nxt = fw_r;
    fh_nxt = fh_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  fw_nxt = cfg_wdata[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_nxt = cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_W'(640);
      fh_r <= FH_W'(480);
    end else begin
      fw_r <= fw_nxt;
      fh_r <= fh_nxt;
    end
  end

  logic [WW-1:0]   fw_ext, w_use;
  logic [CW-1:0]   wlast;
  logic [FH_W-1:0] h_use;
  logic [ROW_W-1:0] hlast;

  always_comb begin
    fw_ext = WW'(fw_r);
    if (fw_ext < W_MIN) begin
      w_use = W_MIN;
    end else if (fw_ext > W_MAX) begin
      w_use = W_MAX;
    end else begin
      w_use = fw_ext;
    end
    wlast = CW'(w_use - WW'(1));
    h_use = (fh_r < H_MIN) ? H_MIN : fh_r;
    hlast = ROW_W'(h_use - FH_W'(1));
  end

  // handshake and counters
  logic adv, accept;
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             col_end, row_end;
  logic [CW-1:0]    col_m1;
  item_tag_t        tag_nxt;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_end = col_r >= wlast;
    row_end = row_r >= hlast;
    col_m1  = col_r - CW'(1);
    tag_nxt.emit      = (row_r >= ROW_W'(INTERIOR_MIN)) && (col_r >= CW'(INTERIOR_MIN));
    tag_nxt.frame_end = col_end && row_end;
    tag_nxt.ccol      = CCOL_W'(col_m1);
    tag_nxt.crow      = row_r - ROW_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line store read
  logic             s1_valid_r;
  item_tag_t        s1_tag_r;
  logic [CW-1:0]    s1_addr_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [2*PIX_W-1:0] ls_rdata;
  logic             s1_move;

  assign s1_move = s1_valid_r && adv;

  sobm_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_addr_r),
    .wdata ({ls_rdata[PIX_W-1:0], s1_pix_r}),
    .re    (accept),
    .raddr (col_r),
    .rdata (ls_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
    if (accept) begin
      s1_tag_r  <= tag_nxt;
      s1_addr_r <= col_r;
      s1_pix_r  <= in_pixel;
    end
  end

  // stage 2: window cell chain, newest column in cell 2
  col_pix_t   col_feed [3];
  col_pix_t   col_fwd  [3];
  col_terms_t terms    [3];

  assign col_feed[2] = '{top: ls_rdata[2*PIX_W-1:PIX_W], mid: ls_rdata[PIX_W-1:0],
                         bot: s1_pix_r};
  assign col_feed[1] = col_fwd[2];
  assign col_feed[0] = col_fwd[1];

  for (genvar g = 0; g < 3; g++) begin : g_cell
    sobm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (s1_move),
      .col_in  (col_feed[g]),
      .col_out (col_fwd[g]),
      .terms   (terms[g])
    );
  end

  logic      s2_valid_r;
  item_tag_t s2_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s1_move) begin
      s2_tag_r <= s1_tag_r;
    end
  end

  // gradient and magnitude
  logic signed [GRAD_W-1:0] gx, gy;
  logic [GRAD_W-2:0]        gx_abs, gy_abs;
  logic [GRAD_W-1:0]        mag_sum;
  logic [MAG_W-1:0]         mag_sat;

  always_comb begin
    gx = $signed({1'b0, terms[0].vsum}) - $signed({1'b0, terms[2].vsum});
    gy = GRAD_W'(terms[0].vdiff) + (GRAD_W'(terms[1].vdiff) <<< 1) + GRAD_W'(terms[2].vdiff);
    gx_abs  = gx[GRAD_W-1] ? (GRAD_W-1)'(-gx) : (GRAD_W-1)'(gx);
    gy_abs  = gy[GRAD_W-1] ? (GRAD_W-1)'(-gy) : (GRAD_W-1)'(gy);
    mag_sum = GRAD_W'(gx_abs) + GRAD_W'(gy_abs);
    mag_sat = (mag_sum > GRAD_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : MAG_W'(mag_sum);
  end

  // output register
  logic              out_valid_r;
  logic [MAG_W-1:0]  magnitude_r;
  logic [CCOL_W-1:0] ccol_r;
  logic [ROW_W-1:0]  crow_r;
  logic              fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r && s2_tag_r.emit;
    end
    if (adv && s2_valid_r) begin
      magnitude_r <= mag_sat;
      ccol_r      <= s2_tag_r.ccol;
      crow_r      <= s2_tag_r.crow;
      fe_r        <= s2_tag_r.frame_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_magnitude  = magnitude_r;
  assign out_centre_col = ccol_r;
  assign out_centre_row = crow_r;
  assign out_frame_end  = fe_r;

  `SOBM_ASSERT_NOW(a_interior_row, s1_valid_r && s1_tag_r.emit, s1_tag_r.crow != '0)
  `SOBM_ASSERT_NEXT(a_frame_wrap, accept && tag_nxt.frame_end, row_r == '0 && col_r == '0)
  `SOBM_ASSERT_NOW(a_out_source, $rose(out_valid_r), $past(s2_valid_r))

endmodule

[sv/sobm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sobm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/sobm_cell.sv]
// One window column cell: holds three pixels, forwards them, forms column terms.
`timescale 1ns / 1ps
module sobm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift,
  input  sobm_pkg::col_pix_t  col_in,
  output sobm_pkg::col_pix_t  col_out,
  output sobm_pkg::col_terms_t terms
);
  import sobm_pkg::*;

  col_pix_t col_r;
  col_pix_t col_nxt;

  always_comb begin
    col_nxt = shift ? col_in : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

  always_comb begin
    terms.vsum  = VSUM_W'(col_r.top) + {1'b0, col_r.mid, 1'b0} + VSUM_W'(col_r.bot);
    terms.vdiff = $signed({1'b0, col_r.top}) - $signed({1'b0, col_r.bot});
  end

endmodule
